[src/bitset_range_any_engine_macros.svh]
// Assertion wrappers for the bit store block.
`ifndef BITSET_RANGE_ANY_ENGINE_MACROS_SVH
`define BITSET_RANGE_ANY_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
`define BRA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define BRA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BRA_ASSERT(label, prop, msg)
`define BRA_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[src/bra_pkg.sv]
package bra_pkg;

    localparam int COUNT_W     = 13;
    localparam int INDEX_W     = 12;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_GET   = 2'd1,
        REQ_SET   = 2'd2,
        REQ_ANY   = 2'd3
    } t_req;

    // work handed from front to back
    typedef enum logic [1:0] {
        OP_DONE  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SET   = 2'd2,
        OP_SCAN  = 2'd3
    } t_op;

endpackage

[src/bra_if.sv]
interface bra_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic [bra_pkg::COUNT_W-1:0]  bit_count;
    logic [bra_pkg::INDEX_W-1:0]  bit_index;
    logic                         new_value;
    logic [bra_pkg::COUNT_W-1:0]  range_low;
    logic [bra_pkg::COUNT_W-1:0]  range_high;

    modport source (output valid, req_type, bit_count, bit_index, new_value, range_low,
                    range_high, input ready);
    modport sink (input valid, req_type, bit_count, bit_index, new_value, range_low,
                  range_high, output ready);
endinterface

interface bra_res_if;
    logic valid;
    logic ready;
    logic answer_bit;
    logic bad_request;

    modport source (output valid, answer_bit, bad_request, input ready);
    modport sink (input valid, answer_bit, bad_request, output ready);
endinterface

[src/bra_fifo.sv]
module bra_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_full,
    output logic         o_empty
);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[src/bra_front.sv]
module bra_front #(
    parameter int NUM_BITS  = 4096,
    parameter int WORD_BITS = 32,
    localparam int NUM_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS,
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
    localparam int CMD_W     = $bits(bra_pkg::t_op) + 2 + 2 * AW + 2 * WORD_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bra_req_if.sink          i_req,
    input  logic             i_init_busy,
    input  logic             i_full,
    output logic             o_push,
    output logic [CMD_W-1:0] o_cmd
);

    localparam int BW    = $clog2(WORD_BITS);
    // reciprocal scaling, exact for every 13-bit dividend
    localparam int SHIFT = 20;
    localparam int RECIP = (2 ** SHIFT + WORD_BITS - 1) / WORD_BITS;
    localparam logic [WORD_BITS-1:0] ALL = '1;
    localparam logic [WORD_BITS-1:0] ONE = {{(WORD_BITS - 1){1'b0}}, 1'b1};

    typedef struct packed {
        bra_pkg::t_op         op;
        logic                 bad;
        logic                 set_val;
        logic [AW-1:0]        word_lo;
        logic [AW-1:0]        word_hi;
        logic [WORD_BITS-1:0] mask_lo;
        logic [WORD_BITS-1:0] mask_hi;
    } t_cmd;

    typedef struct packed {
        logic [12:0]   q;
        logic [BW-1:0] r;
    } t_dm;

    function automatic t_dm split(input logic [12:0] x);
        logic [31:0] prod;
        t_dm         d;
        prod = 32'(x) * 32'(RECIP);
        d.q  = 13'(prod >> SHIFT);
        d.r  = BW'(x - 13'(d.q * 13'(WORD_BITS)));
        return d;
    endfunction

    logic [bra_pkg::COUNT_W-1:0] r_size;
    t_cmd                        cmd;
    t_dm                         d_idx;
    t_dm                         d_lo;
    t_dm                         d_hm;

    assign i_req.ready = !i_full && !i_init_busy;
    assign o_push      = i_req.valid && i_req.ready;
    assign o_cmd       = cmd;

    always_comb begin
        d_idx = split({1'b0, i_req.bit_index});
        d_lo  = split(i_req.range_low);
        d_hm  = split(i_req.range_high - 13'd1);

        cmd         = '0;
        cmd.op      = bra_pkg::OP_DONE;
        cmd.set_val = i_req.new_value;
        unique case (bra_pkg::t_req'(i_req.req_type))
            bra_pkg::REQ_CLEAR: begin
                if (32'(i_req.bit_count) > 32'(NUM_BITS)) begin
                    cmd.bad = 1'b1;
                end else begin
                    cmd.op = bra_pkg::OP_CLEAR;
                end
            end
            bra_pkg::REQ_GET, bra_pkg::REQ_SET: begin
                if ({1'b0, i_req.bit_index} >= r_size) begin
                    cmd.bad = 1'b1;
                end else begin
                    // a get is a one-word scan with a single-bit mask
                    cmd.op      = (bra_pkg::t_req'(i_req.req_type) == bra_pkg::REQ_GET)
                                  ? bra_pkg::OP_SCAN : bra_pkg::OP_SET;
                    cmd.word_lo = d_idx.q[AW-1:0];
                    cmd.word_hi = d_idx.q[AW-1:0];
                    cmd.mask_lo = ONE << d_idx.r;
                    cmd.mask_hi = ONE << d_idx.r;
                end
            end
            bra_pkg::REQ_ANY: begin
                if (i_req.range_low > r_size || i_req.range_high > r_size) begin
                    cmd.bad = 1'b1;
                end else if (i_req.range_low < i_req.range_high) begin
                    cmd.op      = bra_pkg::OP_SCAN;
                    cmd.word_lo = d_lo.q[AW-1:0];
                    cmd.word_hi = d_hm.q[AW-1:0];
                    cmd.mask_lo = ALL << d_lo.r;
                    cmd.mask_hi = ALL >> (BW'(WORD_BITS - 1) - d_hm.r);
                end
            end
        endcase
    end

    // size tracked here so later words classify against it in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else if (o_push && cmd.op == bra_pkg::OP_CLEAR) begin
            r_size <= i_req.bit_count;
        end
    end

endmodule

[src/bra_back.sv]
module bra_back #(
    parameter int NUM_BITS  = 4096,
    parameter int WORD_BITS = 32,
    localparam int NUM_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS,
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
    localparam int CMD_W     = $bits(bra_pkg::t_op) + 2 + 2 * AW + 2 * WORD_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  logic [CMD_W-1:0] i_cmd,
    output logic             o_pop,
    output logic             o_init_busy,
    bra_res_if.source        o_res
);

    localparam logic [WORD_BITS-1:0] ALL = '1;

    typedef struct packed {
        bra_pkg::t_op         op;
        logic                 bad;
        logic                 set_val;
        logic [AW-1:0]        word_lo;
        logic [AW-1:0]        word_hi;
        logic [WORD_BITS-1:0] mask_lo;
        logic [WORD_BITS-1:0] mask_hi;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_SETWB
    } t_state;

    t_state               r_state;
    t_cmd                 cmd_in;
    t_cmd                 r_cmd;
    logic [AW-1:0]        r_addr;
    logic                 r_out_valid;
    logic                 r_out_ans;
    logic                 r_out_bad;
    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    logic                 out_free;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 we;
    logic [AW-1:0]        wa;
    logic [WORD_BITS-1:0] wd;
    logic [WORD_BITS-1:0] word_mask;
    logic                 hit;
    logic                 last_word;
    logic                 scan_end;

    assign cmd_in      = i_cmd;
    assign out_free    = !r_out_valid || o_res.ready;
    assign o_pop       = (r_state == ST_IDLE) && i_cmd_valid && out_free;
    assign o_init_busy = (r_state == ST_INIT);

    assign o_res.valid       = r_out_valid;
    assign o_res.answer_bit  = r_out_ans;
    assign o_res.bad_request = r_out_bad;

    // r_addr is the sweep address, or the word whose data sits in r_rdata
    assign last_word = (r_addr == AW'(NUM_WORDS - 1));
    assign scan_end  = (r_addr == r_cmd.word_hi);
    assign word_mask = ((r_addr == r_cmd.word_lo) ? r_cmd.mask_lo : ALL)
                     & (scan_end ? r_cmd.mask_hi : ALL);
    assign hit       = |(r_rdata & word_mask);

    always_comb begin
        rd_en   = o_pop || (r_state == ST_SCAN && !scan_end);
        rd_addr = (r_state == ST_SCAN) ? r_addr + 1'b1 : cmd_in.word_lo;
        we      = (r_state == ST_INIT) || (r_state == ST_CLEAR) || (r_state == ST_SETWB);
        wa      = (r_state == ST_SETWB) ? r_cmd.word_lo : r_addr;
        wd      = '0;
        if (r_state == ST_SETWB) begin
            wd = r_cmd.set_val ? (r_rdata | r_cmd.mask_lo) : (r_rdata & ~r_cmd.mask_lo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        if (we) begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_INIT, ST_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (last_word) begin
                        r_state <= ST_IDLE;
                        if (r_state == ST_CLEAR) begin
                            r_out_valid <= 1'b1;
                            r_out_ans   <= 1'b0;
                            r_out_bad   <= 1'b0;
                        end
                    end
                end
                ST_IDLE: begin
                    if (o_pop) begin
                        r_cmd  <= cmd_in;
                        r_addr <= cmd_in.word_lo;
                        unique case (cmd_in.op)
                            bra_pkg::OP_DONE: begin
                                r_out_valid <= 1'b1;
                                r_out_ans   <= 1'b0;
                                r_out_bad   <= cmd_in.bad;
                            end
                            bra_pkg::OP_CLEAR: begin
                                r_addr  <= '0;
                                r_state <= ST_CLEAR;
                            end
                            bra_pkg::OP_SET: begin
                                r_state <= ST_SETWB;
                            end
                            bra_pkg::OP_SCAN: begin
                                r_state <= ST_SCAN;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (hit || scan_end) begin
                        r_out_valid <= 1'b1;
                        r_out_ans   <= hit;
                        r_out_bad   <= 1'b0;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_SETWB: begin
                    r_out_valid <= 1'b1;
                    r_out_ans   <= 1'b0;
                    r_out_bad   <= 1'b0;
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[src/bitset_range_any_engine.sv]
// channel  | dir | port  | word
// ---------+-----+-------+----------------------------------------------------
// request  | in  | i_req | req_type, bit_count, bit_index, new_value, range_*
// result   | out | o_res | answer_bit, bad_request
//
// Front classifies a request in the cycle it is taken; a two-word queue feeds
// the back, which owns the word memory (one read, one write port).
// Back: a get reads its word and tests it, a set reads it and writes it back,
// an error or empty range is answered as taken, a clear sweeps all NUM_WORDS
// words, and an any reads the words spanned (one word read per cycle, stops on
// a hit). After reset a clearing pass zeroes every word; i_req.ready stays low.
// Results wait in an output register; a stalled o_res holds the back, and once
// the queue is full i_req.ready drops too.
`include "bitset_range_any_engine_macros.svh"

module bitset_range_any_engine #(
    parameter int NUM_BITS  = 4096,
    parameter int WORD_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bra_req_if.sink   i_req,
    bra_res_if.source o_res
);

    localparam int NUM_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CMD_W     = $bits(bra_pkg::t_op) + 2 + 2 * AW + 2 * WORD_BITS;

    logic             fifo_push;
    logic             fifo_pop;
    logic             fifo_full;
    logic             fifo_empty;
    logic [CMD_W-1:0] push_cmd;
    logic [CMD_W-1:0] head_cmd;
    logic             init_busy;

    bra_front #(
        .NUM_BITS  (NUM_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_init_busy (init_busy),
        .i_full      (fifo_full),
        .o_push      (fifo_push),
        .o_cmd       (push_cmd)
    );

    bra_fifo #(
        .W     (CMD_W),
        .DEPTH (bra_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_wdata (push_cmd),
        .i_pop   (fifo_pop),
        .o_rdata (head_cmd),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    bra_back #(
        .NUM_BITS  (NUM_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!fifo_empty),
        .i_cmd       (head_cmd),
        .o_pop       (fifo_pop),
        .o_init_busy (init_busy),
        .o_res       (o_res)
    );

    `BRA_ASSERT(a_no_take_in_init, init_busy |-> !i_req.ready, "request taken during clearing pass")
    `BRA_ASSERT(a_push_not_full, fifo_push |-> !fifo_full, "queue overrun")
    `BRA_ASSERT(a_pop_not_empty, fifo_pop |-> !fifo_empty, "queue underrun")
    `BRA_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_res.valid, "result valid out of reset")

endmodule
